// ===== hdl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 package
// Types, S-box tables and GF(2^8) helpers shared by the engine files.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

  typedef logic [127:0] blk_t;

  localparam int unsigned NumRounds = 10;

  localparam logic [1:0] SWAP_NONE = 2'd0;
  localparam logic [1:0] SWAP_HALF = 2'd1;
  localparam logic [1:0] SWAP_BYTE = 2'd2;
  localparam logic [1:0] SWAP_BITS = 2'd3;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_DECRYPT  = 2'd2;
  localparam logic [1:0] REG_SWAP     = 2'd3;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // State byte i sits at bits 127-8i down to 120-8i.
  function automatic logic [7:0] get_byte(input blk_t s, input int unsigned i);
    get_byte = s[127-8*i -: 8];
  endfunction

  function automatic logic [31:0] swap_word(input logic [31:0] w, input logic [1:0] mode);
    logic [31:0] r;
    r = w;
    case (mode)
      SWAP_HALF: r = {w[15:0], w[31:16]};
      SWAP_BYTE: r = {w[7:0], w[15:8], w[23:16], w[31:24]};
      SWAP_BITS: for (int i = 0; i < 32; i++) r[31-i] = w[i];
      default:   r = w;
    endcase
    swap_word = r;
  endfunction

  function automatic blk_t swap_block(input blk_t b, input logic [1:0] mode);
    swap_block = {swap_word(b[127:96], mode), swap_word(b[95:64], mode),
                  swap_word(b[63:32], mode), swap_word(b[31:0], mode)};
  endfunction

  // One key expansion round: next round key from the previous one.
  function automatic blk_t key_step(input blk_t k, input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/aes_round.sv =====
// ----------------------------------------------------------------------------
// AES round stage
// One registered cipher or inverse-cipher round with its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_round #(
  parameter bit LastRound = 1'b0
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  input  wire              decrypt,
  input  aes_pkg::blk_t    state_in,
  input  aes_pkg::blk_t    round_key,
  output logic             out_valid,
  output aes_pkg::blk_t    state_out
);

  aes_pkg::blk_t sub_s;
  aes_pkg::blk_t mix_s;
  aes_pkg::blk_t state_next;

  // Encrypt: SubBytes, ShiftRows, MixColumns, AddRoundKey.
  // Decrypt: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns. Last round: no mix.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (decrypt) begin
          sub_s[127-8*(r+4*c) -: 8] =
            aes_pkg::INV_SBOX[aes_pkg::get_byte(state_in, r + 4*((c + 4 - r) % 4))];
        end else begin
          sub_s[127-8*(r+4*c) -: 8] =
            aes_pkg::SBOX[aes_pkg::get_byte(state_in, r + 4*((c + r) % 4))];
        end
      end
    end
  end

  always_comb begin
    logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
    aes_pkg::blk_t pre;
    pre = decrypt ? (sub_s ^ round_key) : sub_s;
    for (int c = 0; c < 4; c++) begin
      a0 = aes_pkg::get_byte(pre, 4*c);
      a1 = aes_pkg::get_byte(pre, 4*c+1);
      a2 = aes_pkg::get_byte(pre, 4*c+2);
      a3 = aes_pkg::get_byte(pre, 4*c+3);
      x0 = aes_pkg::xtime(a0); x1 = aes_pkg::xtime(a1);
      x2 = aes_pkg::xtime(a2); x3 = aes_pkg::xtime(a3);
      y0 = aes_pkg::xtime(x0); y1 = aes_pkg::xtime(x1);
      y2 = aes_pkg::xtime(x2); y3 = aes_pkg::xtime(x3);
      z0 = aes_pkg::xtime(y0); z1 = aes_pkg::xtime(y1);
      z2 = aes_pkg::xtime(y2); z3 = aes_pkg::xtime(y3);
      if (decrypt) begin
        // 14 = 8+4+2, 11 = 8+2+1, 13 = 8+4+1, 9 = 8+1.
        mix_s[127-32*c -: 8] = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
        mix_s[119-32*c -: 8] = (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3);
        mix_s[111-32*c -: 8] = (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3);
        mix_s[103-32*c -: 8] = (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3);
      end else begin
        mix_s[127-32*c -: 8] = x0 ^ (x1^a1) ^ a2 ^ a3;
        mix_s[119-32*c -: 8] = a0 ^ x1 ^ (x2^a2) ^ a3;
        mix_s[111-32*c -: 8] = a0 ^ a1 ^ x2 ^ (x3^a3);
        mix_s[103-32*c -: 8] = (x0^a0) ^ a1 ^ a2 ^ x3;
      end
    end
  end

  always_comb begin
    if (LastRound) begin
      state_next = sub_s ^ round_key;
    end else if (decrypt) begin
      state_next = mix_s;
    end else begin
      state_next = mix_s ^ round_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    state_out <= state_next;
  end

endmodule
`default_nettype wire

// ===== hdl/aes128_ecb_block_engine.sv =====
// ----------------------------------------------------------------------------
// AES-128 ECB block engine
// Fully unrolled cipher and inverse cipher pipeline with word swapping.
// ----------------------------------------------------------------------------
// A block is transferred in when start is high and busy is low; busy is
// never raised, so a new block may enter on every clock cycle.
// The user writes the key, direction and swap mode through cfg_we,
// cfg_index and cfg_data only while no block is in flight, unchecked by the
// block. A key write starts the round key expansion, one round per cycle;
// the round keys then stay in registers. The next start may be transferred
// no earlier than the eleventh clock edge after the last key write.
// The pipeline has an input swap and whitening stage, ten round stages and
// an output swap stage; a result appears with done high once its block has
// passed through all of them. The throughput is one block per cycle, set
// by the unrolled round stages. Results cannot be held off.
// Reset clears the configuration registers to zero, empties the pipeline
// and rebuilds the round keys for the all-zero key.
// ----------------------------------------------------------------------------
`default_nettype none
module aes128_ecb_block_engine (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [63:0] block_high,
  input  wire  [63:0] block_low,
  output logic        done,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [63:0] cfg_data
);

  localparam int unsigned NR = aes_pkg::NumRounds;

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic        decrypt_mode;
  logic [1:0]  swap_mode;

  aes_pkg::blk_t rk [NR+1];
  logic [3:0]    exp_cnt;
  logic          exp_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high     <= '0;
      key_low      <= '0;
      decrypt_mode <= 1'b0;
      swap_mode    <= aes_pkg::SWAP_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        aes_pkg::REG_KEY_HIGH: key_high     <= cfg_data;
        aes_pkg::REG_KEY_LOW:  key_low      <= cfg_data;
        aes_pkg::REG_DECRYPT:  decrypt_mode <= cfg_data[0];
        aes_pkg::REG_SWAP:     swap_mode    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Round key expansion: one key step per cycle into a register per round.
  always_ff @(posedge clk) begin
    if (rst || (cfg_we && (cfg_index == aes_pkg::REG_KEY_HIGH ||
                           cfg_index == aes_pkg::REG_KEY_LOW))) begin
      exp_cnt <= '0;
      exp_run <= 1'b1;
    end else if (exp_run) begin
      if (exp_cnt == 4'(NR - 1)) begin
        exp_run <= 1'b0;
      end
      exp_cnt <= exp_cnt + 4'd1;
    end
  end

  // The first step works from the key registers themselves, since the copy
  // in rk[0] is registered from them and lags behind.
  always_ff @(posedge clk) begin
    rk[0] <= {key_high, key_low};
    for (int i = 1; i <= NR; i++) begin
      if (exp_run && exp_cnt == 4'(i - 1)) begin
        rk[i] <= aes_pkg::key_step((i == 1) ? {key_high, key_low} : rk[i-1],
                                   aes_pkg::RCON[i-1]);
      end
    end
  end

  assign busy = 1'b0;

  // Stage 0: input swap and initial key addition.
  logic          v0;
  aes_pkg::blk_t s0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    s0 <= aes_pkg::swap_block({block_high, block_low}, swap_mode)
          ^ (decrypt_mode ? rk[NR] : rk[0]);
  end

  logic          v   [NR+1];
  aes_pkg::blk_t st  [NR+1];
  assign v[0]  = v0;
  assign st[0] = s0;

  for (genvar g = 1; g <= NR; g++) begin : g_round
    aes_round #(.LastRound(g == NR)) u_round (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[g-1]),
      .decrypt   (decrypt_mode),
      .state_in  (st[g-1]),
      .round_key (decrypt_mode ? rk[NR-g] : rk[g]),
      .out_valid (v[g]),
      .state_out (st[g])
    );
  end

  // Output swap stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v[NR];
    end
    {result_high, result_low} <= aes_pkg::swap_block(st[NR], swap_mode);
  end

endmodule
`default_nettype wire

// ===== hdl/aes_ecb_checker.sv =====
// ----------------------------------------------------------------------------
// AES ECB port checker
// Watches the top-level ports for latency and handshake consistency.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_ecb_checker (
  input wire clk,
  input wire rst,
  input wire start,
  input wire busy,
  input wire done
);

  localparam int unsigned Latency = 12;

  // Every accepted block gives a result a fixed number of cycles later.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##Latency done)
    else $error("result missing after accepted block");

  // A result always stems from a transfer a fixed time earlier.
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done && !$past(rst, Latency) |-> $past(start && !busy, Latency))
    else $error("result without matching block");

  a_ready: assert property (@(posedge clk) !busy)
    else $error("engine stalled the sender");

  a_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result shown after reset");

endmodule

bind aes128_ecb_block_engine aes_ecb_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
`default_nettype wire

// ===== test/aes128_ecb_block_engine_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 ECB engine checker
// Watches the configuration port, block transfers in and results out.
// Predicts every result with its own cipher model and compares the results
// in order.
// ----------------------------------------------------------------------------
module aes128_ecb_block_engine_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  input  wire        busy,
  input  wire [63:0] block_high,
  input  wire [63:0] block_low,
  input  wire        done,
  input  wire [63:0] result_high,
  input  wire [63:0] result_low,
  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [63:0] cfg_data,
  output int         errors,
  output int         pending
);

  logic [63:0]   key_hi_q, key_lo_q;
  logic          decrypt_q;
  logic [1:0]    swap_q;
  aes_pkg::blk_t cipher_queue[$];
  logic [7:0]    sub_tab[256];
  logic [7:0]    inv_sub_tab[256];

  initial begin
    errors = 0;
    for (int i = 0; i < 256; i++) begin
      sub_tab[i] = aes_sbox_value(i);
    end
    for (int i = 0; i < 256; i++) begin
      inv_sub_tab[sub_tab[i]] = i[7:0];
    end
  end

  // The S-box is built from the field inverse and the affine map.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] aes_sbox_value(input int v);
    logic [7:0] x, inv, r, cst;
    x = v[7:0];
    cst = 8'h63;
    inv = 8'h00;
    for (int c = 1; c < 256; c++) begin
      if (gf_mul(x, c[7:0]) == 8'h01) inv = c[7:0];
    end
    for (int i = 0; i < 8; i++) begin
      r[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8] ^ inv[(i + 6) % 8]
             ^ inv[(i + 7) % 8] ^ cst[i];
    end
    return r;
  endfunction

  function automatic logic [31:0] word_swap(input logic [31:0] w, input logic [1:0] m);
    logic [31:0] r;
    case (m)
      aes_pkg::SWAP_HALF: r = {w[15:0], w[31:16]};
      aes_pkg::SWAP_BYTE: r = {w[7:0], w[15:8], w[23:16], w[31:24]};
      aes_pkg::SWAP_BITS: for (int i = 0; i < 32; i++) r[i] = w[31-i];
      default:            r = w;
    endcase
    return r;
  endfunction

  function automatic aes_pkg::blk_t aes_block(input aes_pkg::blk_t din);
    logic [7:0] rk[176];
    logic [7:0] s[16], t[16];
    logic [7:0] a0, a1, a2, a3, tmp;
    logic [31:0] w;
    aes_pkg::blk_t dout;
    for (int i = 0; i < 8; i++) begin
      rk[i] = key_hi_q[63-8*i -: 8];
      rk[8+i] = key_lo_q[63-8*i -: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      a0 = rk[i-4]; a1 = rk[i-3]; a2 = rk[i-2]; a3 = rk[i-1];
      if (i % 16 == 0) begin
        tmp = a0;
        a0 = sub_tab[a1] ^ rcon_of(i / 16 - 1);
        a1 = sub_tab[a2]; a2 = sub_tab[a3]; a3 = sub_tab[tmp];
      end
      rk[i] = rk[i-16] ^ a0; rk[i+1] = rk[i-15] ^ a1;
      rk[i+2] = rk[i-14] ^ a2; rk[i+3] = rk[i-13] ^ a3;
    end
    for (int i = 0; i < 4; i++) begin
      w = word_swap(din[127-32*i -: 32], swap_q);
      for (int j = 0; j < 4; j++) s[4*i+j] = w[31-8*j -: 8];
    end
    if (!decrypt_q) begin
      for (int i = 0; i < 16; i++) s[i] ^= rk[i];
      for (int r = 1; r <= 10; r++) begin
        for (int c = 0; c < 4; c++)
          for (int q = 0; q < 4; q++) t[q+4*c] = sub_tab[s[q+4*((c+q)%4)]];
        if (r != 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            t[4*c]   = gf_mul(a0, 8'd2) ^ gf_mul(a1, 8'd3) ^ a2 ^ a3;
            t[4*c+1] = a0 ^ gf_mul(a1, 8'd2) ^ gf_mul(a2, 8'd3) ^ a3;
            t[4*c+2] = a0 ^ a1 ^ gf_mul(a2, 8'd2) ^ gf_mul(a3, 8'd3);
            t[4*c+3] = gf_mul(a0, 8'd3) ^ a1 ^ a2 ^ gf_mul(a3, 8'd2);
          end
        end
        for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r+i];
      end
    end else begin
      for (int i = 0; i < 16; i++) s[i] ^= rk[160+i];
      for (int r = 9; r >= 0; r--) begin
        for (int c = 0; c < 4; c++)
          for (int q = 0; q < 4; q++) t[q+4*c] = inv_sub_tab[s[q+4*((c+4-q)%4)]];
        for (int i = 0; i < 16; i++) t[i] ^= rk[16*r+i];
        if (r != 0) begin
          for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            t[4*c]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
                       ^ gf_mul(a3, 8'd9);
            t[4*c+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
                       ^ gf_mul(a3, 8'd13);
            t[4*c+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
                       ^ gf_mul(a3, 8'd11);
            t[4*c+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
                       ^ gf_mul(a3, 8'd14);
          end
        end
        s = t;
      end
    end
    for (int i = 0; i < 4; i++) begin
      w = {s[4*i], s[4*i+1], s[4*i+2], s[4*i+3]};
      dout[127-32*i -: 32] = word_swap(w, swap_q);
    end
    return dout;
  endfunction

  function automatic logic [7:0] rcon_of(input int n);
    logic [7:0] v;
    v = 8'h01;
    for (int i = 0; i < n; i++) v = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    aes_pkg::blk_t want;
    if (rst) begin
      key_hi_q <= '0; key_lo_q <= '0; decrypt_q <= 1'b0; swap_q <= aes_pkg::SWAP_NONE;
      cipher_queue.delete();
    end else begin
      if (done) begin
        if (cipher_queue.size() == 0) begin
          $display("unexpected result %h %h at %0t", result_high, result_low, $realtime);
          errors++;
        end else begin
          want = cipher_queue.pop_front();
          if (result_high !== want[127:64]) report_mismatch("result_high", result_high,
                                                            want[127:64]);
          if (result_low !== want[63:0]) report_mismatch("result_low", result_low,
                                                         want[63:0]);
        end
      end
      if (start && !busy) cipher_queue.push_back(aes_block({block_high, block_low}));
      if (cfg_we) begin
        case (cfg_index)
          aes_pkg::REG_KEY_HIGH: key_hi_q <= cfg_data;
          aes_pkg::REG_KEY_LOW:  key_lo_q <= cfg_data;
          aes_pkg::REG_DECRYPT:  decrypt_q <= cfg_data[0];
          aes_pkg::REG_SWAP:     swap_q <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
    pending = cipher_queue.size();
  end

endmodule

// ===== test/aes128_ecb_block_engine_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 ECB engine testbench
// Writes a series of keys, directions and swap modes, streams directed and
// random blocks with random gaps, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module aes128_ecb_block_engine_test;

  localparam int WatchLimit = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [63:0] block_high = '0, block_low = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = aes_pkg::REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;
  wire         busy, done;
  wire  [63:0] result_high, result_low;
  int          errors, pending;
  int          idle_cycles = 0;
  int          gap_pct = 0;

  always #4 clk = ~clk;

  aes128_ecb_block_engine dut (.*);

  aes128_ecb_block_engine_checker checker_i (.*);

  // Watchdog: ends the run when nothing is transferred for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
  endtask

  // Stops sending and waits until every expected result has come.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Waits for the pipeline to empty, rewrites the settings and lets the
  // round keys settle.
  task automatic configure(input logic [63:0] kh, input logic [63:0] kl,
                           input logic dec, input logic [1:0] sw);
    drain();
    write_reg(aes_pkg::REG_KEY_HIGH, kh);
    write_reg(aes_pkg::REG_KEY_LOW, kl);
    write_reg(aes_pkg::REG_DECRYPT, (rand64() & ~64'h1) | {63'd0, dec});
    write_reg(aes_pkg::REG_SWAP, (rand64() & ~64'h3) | {62'd0, sw});
    cfg_we <= 1'b0;
    repeat (12) @(posedge clk);
  endtask

  // Leaves start high so that blocks can follow back to back.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1; block_high <= hi; block_low <= lo;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_blocks(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: send_block('0, '1);
        1: send_block('1, rand64());
        default: send_block(rand64(), rand64());
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (12) @(posedge clk);
    // Before any write the key is all zeros, encrypting with no swap.
    send_block('0, '0);
    send_block('1, '1);
    configure(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b0, aes_pkg::SWAP_NONE);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    configure(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1, aes_pkg::SWAP_NONE);
    send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block('0, '1);
    for (int m = 0; m < 4; m++) begin
      configure('1, '1, m[0], m[1:0]);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
      send_block('1, '0);
      configure('0, '0, ~m[0], m[1:0]);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
      send_block('0, '1);
    end
    for (int p = 0; p < 9; p++) begin
      gap_pct = (p < 3) ? 30 : (p < 6) ? 86 : 0;
      configure(rand64(), rand64(), 1'($urandom_range(1)), 2'($urandom_range(3)));
      random_blocks(145);
      // Let the pipeline drain completely once before carrying on.
      if (p == 4) drain();
    end
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
